// ===== hw/rtl/jssd_pkg.sv =====
`default_nettype none

package jssd_pkg;

    localparam int SAMPLE_W = 12;
    localparam int DRIVE_W  = 13;
    localparam int PROD_W   = 2 * SAMPLE_W + 1;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE      = 12'd4095;
    localparam logic [SAMPLE_W-1:0] DEAD_ZONE_RESET = 12'd50;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic load2;
        logic load3;
        logic load4;
        logic load_out;
    } pipe_ctrl_t;

endpackage : jssd_pkg

`default_nettype wire

// ===== hw/rtl/joystick_smooth_scale_deadzone_core.sv =====
// Joystick smoothing, scaling and dead-zone core.
// Input channel: sample_valid, sample_stall and the sample fields. An item is
// taken at a rising edge with sample_valid high and sample_stall low.
// Result channel: result_valid, result_stall, drive_x, drive_y, running_out.
// A result is taken at a rising edge with result_valid high and result_stall low.
// The dead-zone register sits at byte address 0 of the APB port; every other address selects it too.
// Throughput is one item per cycle while result_stall is low, set by the
// five-stage pipeline: averaging, multiply, quotient estimate, quotient
// correction and the dead-zone output register.
// When the receiver stalls, the result register holds and the stages behind it
// keep filling any empty slots; sample_stall rises only when every stage is full.
// Reset clears the averages, the previous button level, all valid flags and
// restores the dead zone to 50.
`default_nettype none

module joystick_smooth_scale_deadzone_core
    import jssd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        sample_valid,
    output logic             sample_stall,
    input  wire sample_t     raw_x,
    input  wire sample_t     raw_y,
    input  wire logic        button_level,
    input  wire sample_t     speed_limit,
    input  wire logic        running_in,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic signed [DRIVE_W-1:0] drive_x,
    output logic signed [DRIVE_W-1:0] drive_y,
    output logic             running_out
);

    sample_t    dead_zone;
    sample_t    avg_x;
    sample_t    avg_y;
    sample_t    speed;
    logic       run1;
    logic       accept;
    pipe_ctrl_t ctrl;
    logic       v1_reg;
    logic       v2_reg;
    logic       v3_reg;
    logic       v4_reg;
    logic       vout_reg;
    logic       run2_reg;
    logic       run3_reg;
    logic       run4_reg;
    logic       runout_reg;

    always_comb
    begin
        ctrl.load_out = v4_reg & (~vout_reg | ~result_stall);
        ctrl.load4    = v3_reg & (~v4_reg | ctrl.load_out);
        ctrl.load3    = v2_reg & (~v3_reg | ctrl.load4);
        ctrl.load2    = v1_reg & (~v2_reg | ctrl.load3);
        sample_stall  = v1_reg & ~ctrl.load2;
        accept        = sample_valid & ~sample_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept | (v1_reg & ~ctrl.load2);
            v2_reg   <= ctrl.load2 | (v2_reg & ~ctrl.load3);
            v3_reg   <= ctrl.load3 | (v3_reg & ~ctrl.load4);
            v4_reg   <= ctrl.load4 | (v4_reg & ~ctrl.load_out);
            vout_reg <= ctrl.load_out | (vout_reg & result_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load2)
        begin
            run2_reg <= run1;
        end
        if (ctrl.load3)
        begin
            run3_reg <= run2_reg;
        end
        if (ctrl.load4)
        begin
            run4_reg <= run3_reg;
        end
        if (ctrl.load_out)
        begin
            runout_reg <= run4_reg;
        end
    end

    jssd_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .dead_zone (dead_zone)
    );

    jssd_smooth u_smooth (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .raw_x        (raw_x),
        .raw_y        (raw_y),
        .button_level (button_level),
        .speed_limit  (speed_limit),
        .running_in   (running_in),
        .avg_x        (avg_x),
        .avg_y        (avg_y),
        .speed        (speed),
        .run          (run1)
    );

    jssd_axis u_axis_x (
        .clk       (clk),
        .ctrl      (ctrl),
        .invert    (1'b0),
        .avg       (avg_x),
        .speed     (speed),
        .dead_zone (dead_zone),
        .drive     (drive_x)
    );

    jssd_axis u_axis_y (
        .clk       (clk),
        .ctrl      (ctrl),
        .invert    (1'b1),
        .avg       (avg_y),
        .speed     (speed),
        .dead_zone (dead_zone),
        .drive     (drive_y)
    );

    assign result_valid = vout_reg;
    assign running_out  = runout_reg;

endmodule : joystick_smooth_scale_deadzone_core

`default_nettype wire

// ===== hw/rtl/jssd_regs.sv =====
`default_nettype none

module jssd_regs
    import jssd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output sample_t          dead_zone
);

    sample_t dead_zone_reg;
    logic    wr_en;

    // Only one register exists, so every address inside the port selects it.
    assign wr_en = psel & penable & pwrite & (paddr == 2'd0 || paddr != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= DEAD_ZONE_RESET;
        end
        else if (wr_en)
        begin
            dead_zone_reg <= pwdata[SAMPLE_W-1:0];
        end
    end

    assign prdata    = {{(32-SAMPLE_W){1'b0}}, dead_zone_reg};
    assign pready    = 1'b1;
    assign dead_zone = dead_zone_reg;

endmodule : jssd_regs

`default_nettype wire

// ===== hw/rtl/jssd_smooth.sv =====
`default_nettype none

module jssd_smooth
    import jssd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    accept,
    input  wire sample_t raw_x,
    input  wire sample_t raw_y,
    input  wire logic    button_level,
    input  wire sample_t speed_limit,
    input  wire logic    running_in,
    output sample_t      avg_x,
    output sample_t      avg_y,
    output sample_t      speed,
    output logic         run
);

    sample_t smooth_x_reg;
    sample_t smooth_x_next;
    sample_t smooth_y_reg;
    sample_t smooth_y_next;
    logic    prev_button_reg;
    sample_t speed_reg;
    logic    run_reg;
    logic    run_next;
    logic [SAMPLE_W+2:0] sum_x;
    logic [SAMPLE_W+2:0] sum_y;

    always_comb
    begin
        sum_x = {2'b00, smooth_x_reg, 1'b0} + {3'b000, smooth_x_reg} + {3'b000, raw_x};
        sum_y = {2'b00, smooth_y_reg, 1'b0} + {3'b000, smooth_y_reg} + {3'b000, raw_y};
        smooth_x_next = sum_x[SAMPLE_W+1:2];
        smooth_y_next = sum_y[SAMPLE_W+1:2];
        run_next = running_in ^ (prev_button_reg & ~button_level);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_x_reg    <= '0;
            smooth_y_reg    <= '0;
            prev_button_reg <= 1'b0;
        end
        else if (accept)
        begin
            smooth_x_reg    <= smooth_x_next;
            smooth_y_reg    <= smooth_y_next;
            prev_button_reg <= button_level;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            speed_reg <= speed_limit;
            run_reg   <= run_next;
        end
    end

    // Each accepted item loads the averages, so they double as the first stage.
    assign avg_x = smooth_x_reg;
    assign avg_y = smooth_y_reg;
    assign speed = speed_reg;
    assign run   = run_reg;

endmodule : jssd_smooth

`default_nettype wire

// ===== hw/rtl/jssd_axis.sv =====
`default_nettype none

module jssd_axis
    import jssd_pkg::*;
(
    input  wire logic       clk,
    input  wire pipe_ctrl_t ctrl,
    input  wire logic       invert,
    input  wire sample_t    avg,
    input  wire sample_t    speed,
    input  wire sample_t    dead_zone,
    output logic signed [DRIVE_W-1:0] drive
);

    logic [PROD_W-1:0]   n2_reg;
    logic [PROD_W-1:0]   n2_next;
    sample_t             speed2_reg;
    logic [PROD_W-1:0]   n3_reg;
    logic [DRIVE_W-1:0]  q0_reg;
    logic [DRIVE_W-1:0]  q0_next;
    sample_t             speed3_reg;
    logic [DRIVE_W-1:0]  q4_reg;
    logic [DRIVE_W-1:0]  q4_next;
    sample_t             speed4_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [DRIVE_W-1:0] drive_next;
    logic [2*SAMPLE_W-1:0] prod;
    logic [PROD_W:0]     approx;
    logic [PROD_W-1:0]   q0_times_fs;
    logic [PROD_W-1:0]   rem;
    logic signed [DRIVE_W:0] diff;
    logic [DRIVE_W:0]    mag;

    // Division by the full scale: a sum of shifted copies gives a quotient
    // that is low by at most one, and the remainder check corrects it.
    always_comb
    begin
        prod    = {{SAMPLE_W{1'b0}}, avg} * {{SAMPLE_W{1'b0}}, speed};
        n2_next = {prod, 1'b0};
        approx  = {1'b0, n2_reg} + {{(SAMPLE_W+1){1'b0}}, n2_reg[PROD_W-1:SAMPLE_W]}
                + {{PROD_W{1'b0}}, n2_reg[PROD_W-1]};
        q0_next = approx[PROD_W-1:SAMPLE_W];
        q0_times_fs = {q0_reg, {SAMPLE_W{1'b0}}} - {{SAMPLE_W{1'b0}}, q0_reg};
        rem     = n3_reg - q0_times_fs;
        q4_next = q0_reg + {{(DRIVE_W-1){1'b0}}, (rem >= {{(SAMPLE_W+1){1'b0}}, FULL_SCALE})};
        if (invert)
        begin
            diff = $signed({2'b00, speed4_reg}) - $signed({1'b0, q4_reg});
        end
        else
        begin
            diff = $signed({1'b0, q4_reg}) - $signed({2'b00, speed4_reg});
        end
        mag = diff[DRIVE_W] ? (~diff + {{DRIVE_W{1'b0}}, 1'b1}) : diff;
        if (mag < {2'b00, dead_zone})
        begin
            drive_next = '0;
        end
        else
        begin
            drive_next = diff[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load2)
        begin
            n2_reg     <= n2_next;
            speed2_reg <= speed;
        end
        if (ctrl.load3)
        begin
            n3_reg     <= n2_reg;
            q0_reg     <= q0_next;
            speed3_reg <= speed2_reg;
        end
        if (ctrl.load4)
        begin
            q4_reg     <= q4_next;
            speed4_reg <= speed3_reg;
        end
        if (ctrl.load_out)
        begin
            drive_reg <= drive_next;
        end
    end

    assign drive = drive_reg;

endmodule : jssd_axis

`default_nettype wire
